// ===== rtl/core/rlhm_pkg.sv =====
`default_nettype none

package rlhm_pkg;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_FAIL_THRESHOLD   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FAIL_CRITICAL    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CONGESTION_STEP  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CONGESTION_CLEAR = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_MS        = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PACKET_BYTES     = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_READY_MTU        = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FAST_INTERVAL    = 3'd7;

  localparam logic [2:0] CMD_CONNECT    = 3'd0;
  localparam logic [2:0] CMD_DISCONNECT = 3'd1;
  localparam logic [2:0] CMD_MTU        = 3'd2;
  localparam logic [2:0] CMD_PARAMS     = 3'd3;
  localparam logic [2:0] CMD_TX         = 3'd4;

  typedef enum logic [2:0] {
    LS_DISC       = 3'd0,
    LS_CONNECTING = 3'd1,
    LS_CONNECTED  = 3'd2,
    LS_READY      = 3'd3,
    LS_CONGESTED  = 3'd4,
    LS_CRITICAL   = 3'd5
  } link_state_t;

  localparam logic [15:0] MTU_DEFAULT   = 16'd23;
  localparam logic [6:0]  CONG_CAP      = 7'd100;
  localparam logic [15:0] FAIL_RUN_MAX  = 16'hFFFF;
  localparam logic [11:0] INTERVAL_MAX  = 12'd4095;
  localparam logic [11:0] BUF_SMALL     = 12'd512;
  localparam logic [11:0] BUF_NORMAL    = 12'd1024;
  localparam logic [11:0] BUF_LARGE     = 12'd2048;

  localparam logic [7:0]  RST_FAIL_THRESHOLD   = 8'd5;
  localparam logic [9:0]  RST_FAIL_CRITICAL    = 10'd20;
  localparam logic [3:0]  RST_CONGESTION_STEP  = 4'd5;
  localparam logic [6:0]  RST_CONGESTION_CLEAR = 7'd20;
  localparam logic [15:0] RST_WINDOW_MS        = 16'd1000;
  localparam logic [9:0]  RST_PACKET_BYTES     = 10'd239;
  localparam logic [9:0]  RST_READY_MTU        = 10'd246;
  localparam logic [11:0] RST_FAST_INTERVAL    = 12'd15;

  typedef struct packed {
    logic [7:0]  fail_threshold;
    logic [9:0]  fail_critical;
    logic [3:0]  congestion_step;
    logic [6:0]  congestion_clear_level;
    logic [15:0] window_ms;
    logic [9:0]  packet_bytes;
    logic [9:0]  ready_mtu;
    logic [11:0] fast_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] time_ms;
    logic [15:0] mtu_value;
    logic [11:0] interval_units;
    logic [8:0]  slave_latency;
    logic        tx_success;
  } evt_t;

  typedef struct packed {
    link_state_t state;
    logic [6:0]  congestion;
    logic [15:0] fail_run;
    logic [31:0] window_begin;
    logic [31:0] throughput;
    logic [15:0] mtu;
    logic [11:0] interval;
    logic [8:0]  latency;
  } lnk_t;

  typedef struct packed {
    logic [2:0]  link_state;
    logic [6:0]  congestion;
    logic [15:0] mtu_now;
    logic [11:0] interval_ms_now;
    logic [8:0]  latency_now;
    logic [31:0] sent_count;
    logic [31:0] failed_count;
    logic [31:0] throughput_bps;
    logic        is_congested;
    logic        is_ready;
    logic [11:0] recommended_buffer;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/rlhm_cfg_regs.sv =====
`default_nettype none

module rlhm_cfg_regs
  import rlhm_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output cfg_t                          cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fail_threshold         <= RST_FAIL_THRESHOLD;
      cfg_r.fail_critical          <= RST_FAIL_CRITICAL;
      cfg_r.congestion_step        <= RST_CONGESTION_STEP;
      cfg_r.congestion_clear_level <= RST_CONGESTION_CLEAR;
      cfg_r.window_ms              <= RST_WINDOW_MS;
      cfg_r.packet_bytes           <= RST_PACKET_BYTES;
      cfg_r.ready_mtu              <= RST_READY_MTU;
      cfg_r.fast_interval_ms       <= RST_FAST_INTERVAL;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FAIL_THRESHOLD:   cfg_r.fail_threshold         <= cfg_wdata[7:0];
        CFG_FAIL_CRITICAL:    cfg_r.fail_critical          <= cfg_wdata[9:0];
        CFG_CONGESTION_STEP:  cfg_r.congestion_step        <= cfg_wdata[3:0];
        CFG_CONGESTION_CLEAR: cfg_r.congestion_clear_level <= cfg_wdata[6:0];
        CFG_WINDOW_MS:        cfg_r.window_ms              <= cfg_wdata[15:0];
        CFG_PACKET_BYTES:     cfg_r.packet_bytes           <= cfg_wdata[9:0];
        CFG_READY_MTU:        cfg_r.ready_mtu              <= cfg_wdata[9:0];
        CFG_FAST_INTERVAL:    cfg_r.fast_interval_ms       <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/core/rlhm_update.sv =====
`default_nettype none

module rlhm_update
  import rlhm_pkg::*;
#(
  parameter int COUNTER_BITS = 32
) (
  input  wire cfg_t                     cfg,
  input  wire evt_t                     evt,
  input  wire lnk_t                     lnk,
  input  wire logic [COUNTER_BITS-1:0]  sent,
  input  wire logic [COUNTER_BITS-1:0]  failed,
  input  wire logic [COUNTER_BITS-1:0]  win_cnt,
  output lnk_t                          lnk_nxt,
  output logic [COUNTER_BITS-1:0]       sent_nxt,
  output logic [COUNTER_BITS-1:0]       failed_nxt,
  output logic [COUNTER_BITS-1:0]       win_cnt_nxt,
  output res_t                          res
);

  localparam logic [COUNTER_BITS-1:0] CNT_ONE = {{(COUNTER_BITS-1){1'b0}}, 1'b1};

  logic [12:0]             iv_full;
  logic [11:0]             iv_sat;
  logic [15:0]             fail_up;
  logic [15:0]             fail_dn;
  logic [6:0]              cong_up;
  logic [6:0]              cong_dn;
  logic [31:0]             elapsed;
  logic                    win_close;
  logic [COUNTER_BITS-1:0] win_inc;
  logic [31:0]             win_prod;
  logic [31:0]             win_bytes;
  logic                    ready_ok;

  // units * 1.25, floored
  assign iv_full = {1'b0, evt.interval_units} + 13'(evt.interval_units[11:2]);
  assign iv_sat  = iv_full[12] ? INTERVAL_MAX : iv_full[11:0];

  assign fail_up = (lnk.fail_run == FAIL_RUN_MAX) ? lnk.fail_run : lnk.fail_run + 16'd1;
  assign fail_dn = (lnk.fail_run == '0) ? lnk.fail_run : lnk.fail_run - 16'd1;
  assign cong_up = (lnk.congestion < CONG_CAP) ?
                   lnk.congestion + {3'b0, cfg.congestion_step} : lnk.congestion;
  assign cong_dn = (lnk.congestion == '0) ? lnk.congestion : lnk.congestion - 7'd1;

  assign elapsed   = evt.time_ms - lnk.window_begin;
  assign win_close = elapsed >= {16'b0, cfg.window_ms};
  assign win_inc   = win_cnt + CNT_ONE;

  // (count + 1) * bytes, with the wrapped count giving zero
  assign win_prod  = 32'(win_cnt) * {22'b0, cfg.packet_bytes};
  assign win_bytes = (win_inc == '0) ? '0 : win_prod + {22'b0, cfg.packet_bytes};

  assign ready_ok = evt.mtu_value >= {6'b0, cfg.ready_mtu};

  always_comb begin
    lnk_nxt     = lnk;
    sent_nxt    = sent;
    failed_nxt  = failed;
    win_cnt_nxt = win_cnt;
    case (evt.cmd)
      CMD_CONNECT: begin
        lnk_nxt.state        = LS_CONNECTING;
        lnk_nxt.congestion   = '0;
        lnk_nxt.fail_run     = '0;
        lnk_nxt.window_begin = evt.time_ms;
        sent_nxt             = '0;
        failed_nxt           = '0;
        win_cnt_nxt          = '0;
      end
      CMD_DISCONNECT: begin
        lnk_nxt.state    = LS_DISC;
        lnk_nxt.mtu      = MTU_DEFAULT;
        lnk_nxt.interval = '0;
      end
      CMD_MTU: begin
        lnk_nxt.mtu   = evt.mtu_value;
        lnk_nxt.state = ready_ok ? LS_READY : LS_CONNECTED;
      end
      CMD_PARAMS: begin
        lnk_nxt.interval = iv_sat;
        lnk_nxt.latency  = evt.slave_latency;
      end
      CMD_TX: begin
        sent_nxt = sent + CNT_ONE;
        if (evt.tx_success) begin
          lnk_nxt.fail_run   = fail_dn;
          lnk_nxt.congestion = cong_dn;
          if (lnk.state == LS_CONGESTED && cong_dn < cfg.congestion_clear_level) begin
            lnk_nxt.state = LS_READY;
          end
          if (lnk.state == LS_CRITICAL && fail_dn == '0) begin
            lnk_nxt.state = LS_CONGESTED;
          end
        end else begin
          failed_nxt         = failed + CNT_ONE;
          lnk_nxt.fail_run   = fail_up;
          lnk_nxt.congestion = cong_up;
          if (fail_up >= {6'b0, cfg.fail_critical}) begin
            lnk_nxt.state = LS_CRITICAL;
          end else if (fail_up >= {8'b0, cfg.fail_threshold} && lnk.state == LS_READY) begin
            lnk_nxt.state = LS_CONGESTED;
          end
        end
        if (win_close) begin
          lnk_nxt.throughput   = win_bytes;
          lnk_nxt.window_begin = evt.time_ms;
          win_cnt_nxt          = '0;
        end else begin
          win_cnt_nxt = win_inc;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res.link_state      = lnk_nxt.state;
    res.congestion      = lnk_nxt.congestion;
    res.mtu_now         = lnk_nxt.mtu;
    res.interval_ms_now = lnk_nxt.interval;
    res.latency_now     = lnk_nxt.latency;
    res.sent_count      = 32'(sent_nxt);
    res.failed_count    = 32'(failed_nxt);
    res.throughput_bps  = lnk_nxt.throughput;
    res.is_congested    = 1'b0;
    res.is_ready        = 1'b0;
    res.recommended_buffer = BUF_NORMAL;
    case (lnk_nxt.state)
      LS_DISC: begin
        res.is_congested = 1'b1;
      end
      LS_READY: begin
        res.is_ready = 1'b1;
        res.recommended_buffer =
          (lnk_nxt.interval <= cfg.fast_interval_ms) ? BUF_SMALL : BUF_NORMAL;
      end
      LS_CONGESTED, LS_CRITICAL: begin
        res.is_congested       = 1'b1;
        res.recommended_buffer = BUF_LARGE;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/radio_link_health_monitor.sv =====
`default_nettype none

// Channel  Direction  Handshake                  Payload
// in_      input      in_valid / in_ready        cmd, time_ms, mtu_value, interval_units,
//                                                slave_latency, tx_success
// out_     output     out_valid / out_ready      link status, counters, buffer hint
// cfg_     input      cfg_we (no wait)           cfg_index, cfg_wdata
//
// One transaction per cycle sustained while out_ready stays high. An accepted event loads
// the event register; the single-pass update then loads its result into the result
// register once that register is empty or out_ready is high. Link state updates together
// with the result register load, so back-to-back events see each other's effects. Reset is
// synchronous and returns link state, counters, valid flags and configuration to defaults.
// A stalled out_ready holds the result and backs up into in_ready.

module radio_link_health_monitor
  import rlhm_pkg::*;
#(
  parameter int COUNTER_BITS = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,

  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [2:0]               in_cmd,
  input  wire logic [31:0]              in_time_ms,
  input  wire logic [15:0]              in_mtu_value,
  input  wire logic [11:0]              in_interval_units,
  input  wire logic [8:0]               in_slave_latency,
  input  wire logic                     in_tx_success,

  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [2:0]                    out_link_state,
  output logic [6:0]                    out_congestion,
  output logic [15:0]                   out_mtu_now,
  output logic [11:0]                   out_interval_ms_now,
  output logic [8:0]                    out_latency_now,
  output logic [31:0]                   out_sent_count,
  output logic [31:0]                   out_failed_count,
  output logic [31:0]                   out_throughput_bps,
  output logic                          out_is_congested,
  output logic                          out_is_ready,
  output logic [11:0]                   out_recommended_buffer,

  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  cfg_t                    cfg;
  evt_t                    evt_r;
  logic                    evt_vld_r;
  lnk_t                    lnk_r;
  lnk_t                    lnk_nxt;
  logic [COUNTER_BITS-1:0] sent_r;
  logic [COUNTER_BITS-1:0] sent_nxt;
  logic [COUNTER_BITS-1:0] failed_r;
  logic [COUNTER_BITS-1:0] failed_nxt;
  logic [COUNTER_BITS-1:0] win_cnt_r;
  logic [COUNTER_BITS-1:0] win_cnt_nxt;
  res_t                    res_nxt;
  res_t                    res_r;
  logic                    res_vld_r;
  logic                    go;

  rlhm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rlhm_update #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_update (
    .cfg         (cfg),
    .evt         (evt_r),
    .lnk         (lnk_r),
    .sent        (sent_r),
    .failed      (failed_r),
    .win_cnt     (win_cnt_r),
    .lnk_nxt     (lnk_nxt),
    .sent_nxt    (sent_nxt),
    .failed_nxt  (failed_nxt),
    .win_cnt_nxt (win_cnt_nxt),
    .res         (res_nxt)
  );

  assign go       = evt_vld_r && (!res_vld_r || out_ready);
  assign in_ready = !evt_vld_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      evt_vld_r <= 1'b0;
    end else if (in_ready) begin
      evt_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      evt_r.cmd            <= in_cmd;
      evt_r.time_ms        <= in_time_ms;
      evt_r.mtu_value      <= in_mtu_value;
      evt_r.interval_units <= in_interval_units;
      evt_r.slave_latency  <= in_slave_latency;
      evt_r.tx_success     <= in_tx_success;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lnk_r.state        <= LS_DISC;
      lnk_r.congestion   <= '0;
      lnk_r.fail_run     <= '0;
      lnk_r.window_begin <= '0;
      lnk_r.throughput   <= '0;
      lnk_r.mtu          <= MTU_DEFAULT;
      lnk_r.interval     <= '0;
      lnk_r.latency      <= '0;
      sent_r             <= '0;
      failed_r           <= '0;
      win_cnt_r          <= '0;
    end else if (go) begin
      lnk_r     <= lnk_nxt;
      sent_r    <= sent_nxt;
      failed_r  <= failed_nxt;
      win_cnt_r <= win_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (go) begin
      res_vld_r <= 1'b1;
    end else if (out_ready) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid              = res_vld_r;
  assign out_link_state         = res_r.link_state;
  assign out_congestion         = res_r.congestion;
  assign out_mtu_now            = res_r.mtu_now;
  assign out_interval_ms_now    = res_r.interval_ms_now;
  assign out_latency_now        = res_r.latency_now;
  assign out_sent_count         = res_r.sent_count;
  assign out_failed_count       = res_r.failed_count;
  assign out_throughput_bps     = res_r.throughput_bps;
  assign out_is_congested       = res_r.is_congested;
  assign out_is_ready           = res_r.is_ready;
  assign out_recommended_buffer = res_r.recommended_buffer;

endmodule

`default_nettype wire
